// File: src/fractional_delay_line_macros.svh
// assertion macros for the fractional delay line rtl
`ifndef FRACTIONAL_DELAY_LINE_MACROS_SVH
`define FRACTIONAL_DELAY_LINE_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define FDL_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("fdl assertion failed");
// next-cycle implication
`define FDL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("fdl assertion failed");
`else
`define FDL_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define FDL_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: src/fdl_pkg.sv
// shared types and constants of the fractional delay line
`default_nettype none
package fdl_pkg;

  localparam int unsigned DEPTH_DEF   = 65536;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned FRAC_BITS   = 16;

  // fixed port widths
  localparam int unsigned LEN_W = 17;
  localparam int unsigned WS_W  = 18;
  localparam int unsigned TAP_W = 16;

  // shared multiply-add unit
  localparam int unsigned MAC_A_W = 36;
  localparam int unsigned MAC_B_W = 18;
  localparam int unsigned MAC_C_W = 55;

  typedef struct packed {
    logic                        en;
    logic signed [MAC_A_W-1:0]   a;
    logic signed [MAC_B_W-1:0]   b;
    logic signed [MAC_C_W-1:0]   c;
  } mac_op_t;

  // divide by six, one byte per step
  localparam int unsigned DIV_W      = 40;
  localparam int unsigned DIV_DIGIT  = 8;
  localparam logic [2:0]  DIV_STEPS  = 3'd5;
  localparam logic [10:0] DIV6_RECIP = 11'd1366;
  localparam int unsigned DIV6_SHIFT = 13;

  // bias that keeps the dividend positive, and its image in the quotient
  localparam logic signed [DIV_W-1:0] DIV_BIAS   = 40'sd51539607552;
  localparam logic signed [DIV_W-1:0] QUO_OFFSET = 40'sd8589934592;

endpackage
`default_nettype wire

// File: src/fdl_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none
module fdl_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                            wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// File: src/fdl_mac.sv
// shared multiply-add unit with registered result
`default_nettype none
module fdl_mac (
  input  wire logic                                  clk_i,
  input  wire fdl_pkg::mac_op_t                      op_i,
  output logic signed [fdl_pkg::MAC_C_W-1:0]         acc_o
);

  logic signed [fdl_pkg::MAC_A_W+fdl_pkg::MAC_B_W-1:0] prod;
  logic signed [fdl_pkg::MAC_C_W-1:0]                  acc_d;
  logic signed [fdl_pkg::MAC_C_W-1:0]                  acc_q;

  assign prod  = op_i.a * op_i.b;
  assign acc_d = fdl_pkg::MAC_C_W'(prod) + op_i.c;

  always_ff @(posedge clk_i) begin
    if (op_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule
`default_nettype wire

// File: src/fdl_div6.sv
// floor division by six, one byte of the dividend per cycle
`default_nettype none
module fdl_div6 (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [fdl_pkg::DIV_W-1:0]   num_i,
  output logic                             done_o,
  output logic      [fdl_pkg::DIV_W-1:0]   quo_o
);

  logic [2:0]                    cnt_q;
  logic                          done_q;
  logic [2:0]                    rem_q;
  logic [fdl_pkg::DIV_W-1:0]     num_q;
  logic [fdl_pkg::DIV_W-1:0]     quo_q;
  logic [10:0]                   part;
  logic [21:0]                   prod;
  logic [fdl_pkg::DIV_DIGIT-1:0] digit;
  logic [10:0]                   back;

  // partial remainder and next byte, below 1536
  assign part  = {rem_q, num_q[fdl_pkg::DIV_W-1 -: fdl_pkg::DIV_DIGIT]};
  assign prod  = 22'(part) * 22'(fdl_pkg::DIV6_RECIP);
  assign digit = prod[fdl_pkg::DIV6_SHIFT +: fdl_pkg::DIV_DIGIT];
  assign back  = (11'(digit) << 2) + (11'(digit) << 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == 3'd1);
      if (start_i) begin
        cnt_q <= fdl_pkg::DIV_STEPS;
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      num_q <= num_q << fdl_pkg::DIV_DIGIT;
      quo_q <= {quo_q[fdl_pkg::DIV_W-fdl_pkg::DIV_DIGIT-1:0], digit};
      rem_q <= 3'(part - back);
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

// File: src/fractional_delay_line.sv
// top level of the fractional delay line: sequencer, store and cubic tap
//
//  channel   | handshake                | payload
//  ----------+--------------------------+-------------------------------------------
//  input     | start, busy              | req_type_i, write_sample_i, tap_position_i
//  result    | done_o (one-cycle strobe) | tap_sample_o
//  config    | cfg_valid_i, cfg_ready_o | cfg_data_i (line length)
//
// a write word is taken without raising busy, so writes can come every cycle while the line is idle
// a read word keeps busy high while it makes four reads through the single ram read port,
//   four passes through the shared multiply-add unit and a five-step divide by six;
//   done_o pulses in the first cycle with busy low
// after reset the store is swept to zero, one entry a cycle, with busy held high;
//   config writes are still taken during the sweep
// config is held off while start is high in idle, so a word and a length never land together
// the result receiver cannot stall; every read result is shown for exactly one cycle
`default_nettype none
`include "fractional_delay_line_macros.svh"
module fractional_delay_line #(
  parameter int unsigned DEPTH = fdl_pkg::DEPTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              req_type_i,
  input  wire logic signed [fdl_pkg::WS_W-1:0]   write_sample_i,
  input  wire logic        [fdl_pkg::TAP_W-1:0]  tap_position_i,
  output logic                                   done_o,
  output logic signed [fdl_pkg::SAMPLE_BITS-1:0] tap_sample_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic        [fdl_pkg::LEN_W-1:0]  cfg_data_i
);

  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned IX_W   = fdl_pkg::LEN_W + 1;
  localparam int unsigned SB     = fdl_pkg::SAMPLE_BITS;
  localparam int unsigned FB     = fdl_pkg::FRAC_BITS;
  localparam int unsigned LW     = fdl_pkg::LEN_W;
  localparam int unsigned RW     = fdl_pkg::MAC_A_W;

  localparam logic [LW-1:0]     LEN_RST   = (DEPTH < 65536) ? LW'(DEPTH) : LW'(65536);
  localparam logic [LW-1:0]     LEN_MIN   = LW'(4);
  localparam logic [20:0]       DEPTH_V   = 21'(DEPTH);
  localparam logic [LW-1:0]     DEPTH_LEN = LW'(DEPTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [FB:0]       ONE_F     = {1'b1, {FB{1'b0}}};

  localparam logic signed [36:0] SAT_HI = 37'((1 << (SB - 1)) - 1);
  localparam logic signed [36:0] SAT_LO = -SAT_HI - 37'sd1;
  localparam logic signed [36:0] Y_HALF = 37'sd1 <<< (FB - 1);
  localparam logic signed [fdl_pkg::MAC_C_W-1:0] MAC_HALF =
    fdl_pkg::MAC_C_W'(1) << (FB - 1);

  // sequencer states
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_CLEAR  = 4'd1;
  localparam logic [3:0] ST_IDX    = 4'd2;
  localparam logic [3:0] ST_ADR    = 4'd3;
  localparam logic [3:0] ST_RA     = 4'd4;
  localparam logic [3:0] ST_RB     = 4'd5;
  localparam logic [3:0] ST_RC     = 4'd6;
  localparam logic [3:0] ST_RD     = 4'd7;
  localparam logic [3:0] ST_RE     = 4'd8;
  localparam logic [3:0] ST_PMUL   = 4'd9;
  localparam logic [3:0] ST_RMUL   = 4'd10;
  localparam logic [3:0] ST_DSTART = 4'd11;
  localparam logic [3:0] ST_DWAIT  = 4'd12;
  localparam logic [3:0] ST_TMUL   = 4'd13;
  localparam logic [3:0] ST_OUT    = 4'd14;

  function automatic logic signed [SB-1:0] sat_sample(input logic signed [36:0] v);
    logic signed [36:0] r;
    r = v;
    if (v > SAT_HI) begin
      r = SAT_HI;
    end else if (v < SAT_LO) begin
      r = SAT_LO;
    end
    return SB'(r);
  endfunction

  // control state
  logic [3:0]        state_q, state_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [ADDR_W-1:0] head_q, head_d;
  logic [LW-1:0]     len_q, len_d;
  logic              done_q, done_d;

  // datapath registers
  logic [fdl_pkg::TAP_W-1:0] pos_q;
  logic [IX_W-1:0]         i0_q;
  logic [FB-1:0]           f_q;
  logic signed [SB-1:0]    a_q, b_q, c_q;
  logic signed [18:0]      k1_q, k0_q;
  logic signed [LW-1:0]    cb_q;
  logic signed [34:0]      x_q;
  logic signed [SB-1:0]    res_q;

  // handshakes
  logic accept, wr_acc, rd_acc, cfg_fire;

  // length and head
  logic [LW-1:0]   cfg_len;
  logic [IX_W-1:0] len_ix, head_ix, head_inc;

  // index math
  logic [LW-1:0]   q_idx;
  logic [IX_W-1:0] ip, i0_calc, im, i1p, i1, i2p, i2, rd_ix;

  // ram
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [SB-1:0]     ram_wdata, ram_rdata;
  logic signed [SB-1:0] rd_s;

  // arithmetic
  fdl_pkg::mac_op_t                   mac_op;
  logic signed [fdl_pkg::MAC_C_W-1:0] mac_acc;
  logic signed [RW-1:0]               mac_hi;
  logic [FB:0]                        omf;
  logic signed [18:0]                 d19, a19, b19, c19, cb19, k1_calc, k0_calc;
  logic signed [fdl_pkg::DIV_W-1:0]   n40, s40;
  logic [fdl_pkg::DIV_W-1:0]          div_quo;
  logic                               div_start, div_done;
  logic signed [34:0]                 x_calc;
  logic signed [36:0]                 y37, yr;

  assign busy        = (state_q != ST_IDLE);
  // no length write while a word is offered in idle
  assign cfg_ready_o = ((state_q == ST_IDLE) && !start) || (state_q == ST_CLEAR);
  assign accept      = start && !busy;
  assign wr_acc      = accept && req_type_i;
  assign rd_acc      = accept && !req_type_i;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  // clamp a written length into 4 .. DEPTH
  always_comb begin
    cfg_len = cfg_data_i;
    if (cfg_data_i < LEN_MIN) begin
      cfg_len = LEN_MIN;
    end else if ({4'b0, cfg_data_i} > DEPTH_V) begin
      cfg_len = DEPTH_LEN;
    end
  end

  assign len_ix   = IX_W'(len_q);
  assign head_ix  = IX_W'(head_q);
  assign head_inc = head_ix + IX_W'(1);

  // head advance on writes, snap to zero when the line shrinks under it
  always_comb begin
    head_d = head_q;
    len_d  = len_q;
    if (cfg_fire) begin
      len_d = cfg_len;
      if (head_ix >= IX_W'(cfg_len)) begin
        head_d = '0;
      end
    end else if (wr_acc) begin
      head_d = (head_inc >= len_ix) ? '0 : ADDR_W'(head_inc);
    end
  end

  // tap index: head + floor(len * (1 - pos)), wrapped once
  assign q_idx   = mac_acc[FB +: LW];
  assign ip      = head_ix + IX_W'(q_idx);
  assign i0_calc = (ip >= len_ix) ? ip - len_ix : ip;

  // neighbours of the tap
  assign im  = (i0_q == '0) ? len_ix - IX_W'(1) : i0_q - IX_W'(1);
  assign i1p = i0_q + IX_W'(1);
  assign i1  = (i1p >= len_ix) ? i1p - len_ix : i1p;
  assign i2p = i0_q + IX_W'(2);
  assign i2  = (i2p >= len_ix) ? i2p - len_ix : i2p;

  always_comb begin
    case (state_q)
      ST_RA:   rd_ix = im;
      ST_RB:   rd_ix = i0_q;
      ST_RC:   rd_ix = i1;
      ST_RD:   rd_ix = i2;
      default: rd_ix = i0_q;
    endcase
  end

  // one write port shared by the clearing sweep and sample writes
  assign ram_we    = (state_q == ST_CLEAR) || wr_acc;
  assign ram_waddr = (state_q == ST_CLEAR) ? clr_q : head_q;
  assign ram_wdata = (state_q == ST_CLEAR) ? '0 : sat_sample(37'(write_sample_i));
  assign ram_raddr = ADDR_W'(rd_ix);

  fdl_ram #(
    .WIDTH (SB),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_s = signed'(ram_rdata);

  // cubic coefficients, d arrives straight from the ram
  assign d19     = 19'(rd_s);
  assign a19     = 19'(a_q);
  assign b19     = 19'(b_q);
  assign c19     = 19'(c_q);
  assign cb19    = c19 - b19;
  assign k1_calc = d19 - a19 - (cb19 + (cb19 <<< 1));
  assign k0_calc = d19 + (a19 <<< 1) - (b19 + (b19 <<< 1));

  assign omf    = ONE_F - (FB + 1)'(f_q);
  assign mac_hi = signed'(mac_acc[FB +: RW]);

  // operand select for the shared multiply-add
  always_comb begin
    mac_op    = '0;
    case (state_q)
      ST_IDX: begin
        // len * (1 - pos) in Q.16
        mac_op.en = 1'b1;
        mac_op.a  = signed'(RW'(len_q));
        mac_op.b  = signed'(fdl_pkg::MAC_B_W'(ONE_F - (FB + 1)'(pos_q)));
        mac_op.c  = '0;
      end
      ST_PMUL: begin
        // p = k1 * f + k0 * one
        mac_op.en = 1'b1;
        mac_op.a  = RW'(k1_q);
        mac_op.b  = signed'(fdl_pkg::MAC_B_W'(f_q));
        mac_op.c  = fdl_pkg::MAC_C_W'(k0_q) <<< FB;
      end
      ST_RMUL: begin
        // r = round(p * (one - f) / one)
        mac_op.en = 1'b1;
        mac_op.a  = signed'(mac_acc[RW-1:0]);
        mac_op.b  = signed'(fdl_pkg::MAC_B_W'(omf));
        mac_op.c  = MAC_HALF;
      end
      ST_TMUL: begin
        // t = round((cb * one - s) * f / one)
        mac_op.en = 1'b1;
        mac_op.a  = RW'(x_q);
        mac_op.b  = signed'(fdl_pkg::MAC_B_W'(f_q));
        mac_op.c  = MAC_HALF;
      end
      default: mac_op = '0;
    endcase
  end

  fdl_mac u_mac (
    .clk_i (clk_i),
    .op_i  (mac_op),
    .acc_o (mac_acc)
  );

  // s = floor((r + 3) / 6), biased so the divider sees a positive word
  assign n40       = fdl_pkg::DIV_W'(mac_hi) + 40'sd3 + fdl_pkg::DIV_BIAS;
  assign div_start = (state_q == ST_DSTART);

  fdl_div6 u_div6 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (unsigned'(n40)),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign s40    = signed'(div_quo) - fdl_pkg::QUO_OFFSET;
  assign x_calc = (35'(cb_q) <<< FB) - 35'(s40);

  // final value: round((b * one + t) / one)
  assign y37 = (37'(b_q) <<< FB) + 37'(mac_hi);
  assign yr  = (y37 + Y_HALF) >>> FB;

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    done_d  = (state_q == ST_OUT);
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + ADDR_W'(1);
        if (clr_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (rd_acc) begin
          state_d = ST_IDX;
        end
      end
      ST_IDX:    state_d = ST_ADR;
      ST_ADR:    state_d = ST_RA;
      ST_RA:     state_d = ST_RB;
      ST_RB:     state_d = ST_RC;
      ST_RC:     state_d = ST_RD;
      ST_RD:     state_d = ST_RE;
      ST_RE:     state_d = ST_PMUL;
      ST_PMUL:   state_d = ST_RMUL;
      ST_RMUL:   state_d = ST_DSTART;
      ST_DSTART: state_d = ST_DWAIT;
      ST_DWAIT: begin
        if (div_done) begin
          state_d = ST_TMUL;
        end
      end
      ST_TMUL:   state_d = ST_OUT;
      ST_OUT:    state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      head_q  <= '0;
      len_q   <= LEN_RST;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      head_q  <= head_d;
      len_q   <= len_d;
      done_q  <= done_d;
    end
  end

  // datapath captures, made in the sequencer steps that need them
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        // hold the tap position, the sender may move on after the accept
        if (rd_acc) begin
          pos_q <= tap_position_i;
        end
      end
      ST_ADR: begin
        i0_q <= i0_calc;
        f_q  <= mac_acc[FB-1:0];
      end
      ST_RB: a_q <= rd_s;
      ST_RC: b_q <= rd_s;
      ST_RD: c_q <= rd_s;
      ST_RE: begin
        k1_q <= k1_calc;
        k0_q <= k0_calc;
        cb_q <= LW'(cb19);
      end
      ST_DWAIT: begin
        if (div_done) begin
          x_q <= x_calc;
        end
      end
      ST_OUT: res_q <= sat_sample(yr);
      default: ;
    endcase
  end

  assign done_o       = done_q;
  assign tap_sample_o = res_q;

  `FDL_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o)
  `FDL_ASSERT_IMP(a_head_below_len, clk_i, rst_ni, 1'b1, head_ix < len_ix)
  `FDL_ASSERT_NEXT(a_write_no_busy, clk_i, rst_ni, start && !busy && req_type_i, !busy)
  `FDL_ASSERT_NEXT(a_read_goes_busy, clk_i, rst_ni, start && !busy && !req_type_i,
                   busy && !done_o)

endmodule
`default_nettype wire

// File: tb/tb_top.sv
// self-checking testbench for the fractional delay line: directed and random words
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

  localparam int unsigned STORE_DEPTH = fdl_pkg::DEPTH_DEF;
  localparam int unsigned SW          = fdl_pkg::SAMPLE_BITS;
  localparam longint      UNITY       = longint'(1) <<< fdl_pkg::FRAC_BITS;
  localparam longint      SAMPLE_MAX  = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint      SAMPLE_MIN  = -(longint'(1) <<< (SW - 1));
  localparam int unsigned MIN_LENGTH  = 4;
  // a read keeps busy high while it runs, then done follows
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned DRAIN_GUARD   = 4000;
  // reset sweep of the whole store plus every word at its slowest, several times over
  localparam longint      CYCLE_LIMIT   = 600000;
  localparam int unsigned PRINT_CAP     = 20;

  typedef enum logic {
    REQ_READ  = 1'b0,
    REQ_WRITE = 1'b1
  } req_e;

  typedef struct {
    logic signed [SW-1:0] value;
    int                   seq;
  } tap_expect_t;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             start;
  logic                             busy;
  logic                             req_type_i;
  logic signed [fdl_pkg::WS_W-1:0]  write_sample_i;
  logic        [fdl_pkg::TAP_W-1:0] tap_position_i;
  logic                             done_o;
  logic signed [SW-1:0]             tap_sample_o;
  logic                             cfg_valid_i;
  logic                             cfg_ready_o;
  logic        [fdl_pkg::LEN_W-1:0] cfg_data_i;

  fractional_delay_line u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .write_sample_i (write_sample_i),
    .tap_position_i (tap_position_i),
    .done_o         (done_o),
    .tap_sample_o   (tap_sample_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  // shadow of the delay line: store, write head and length in use
  logic signed [SW-1:0] line_mirror [STORE_DEPTH];
  int unsigned          head_idx;
  int unsigned          line_len;

  tap_expect_t pending_taps [$];

  int     mismatches;
  int     writes_sent;
  int     reads_sent;
  int     reads_checked;
  int     length_writes;
  int     max_len_seen;
  longint cycle_count;

  // ---------------------------------------------------------------------------
  // clock and watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d taps still owed", cycle_count,
               pending_taps.size());
      $display("[fractional_delay_line] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // shadow arithmetic
  // ---------------------------------------------------------------------------
  function automatic logic signed [SW-1:0] clip_sample(input longint v);
    if (v > SAMPLE_MAX) return SW'(SAMPLE_MAX);
    if (v < SAMPLE_MIN) return SW'(SAMPLE_MIN);
    return SW'(v);
  endfunction

  // floor division, n > 0
  function automatic longint floor_quot(input longint x, input longint n);
    if (x >= 0) return x / n;
    return -((-x + n - 1) / n);
  endfunction

  // x * y / unity, rounded half up, with 0 <= y <= unity
  function automatic longint frac_scale(input longint x, input longint y);
    longint lo;
    longint hi;
    lo = x & (UNITY - 1);
    hi = (x - lo) / UNITY;
    return hi * y + ((lo * y + UNITY / 2) / UNITY);
  endfunction

  // four-point lagrange tap at head - pos * length
  function automatic logic signed [SW-1:0] cubic_tap(input logic [fdl_pkg::TAP_W-1:0] pos);
    longint span, x, f, a, b, c, d, cb, p, r, s, t, y;
    longint i0, im, i1, i2;
    span = longint'(line_len);
    x = (longint'(head_idx) <<< 16) - longint'(pos) * span + (span <<< 16);
    if (x < 0) x = 0;
    f  = x & 64'hFFFF;
    i0 = (x >>> 16) % span;
    im = (i0 == 0) ? span - 1 : i0 - 1;
    i1 = i0 + 1;
    if (i1 >= span) i1 -= span;
    i2 = i0 + 2;
    if (i2 >= span) i2 -= span;
    a  = longint'(line_mirror[im]);
    b  = longint'(line_mirror[i0]);
    c  = longint'(line_mirror[i1]);
    d  = longint'(line_mirror[i2]);
    cb = c - b;
    p  = (d - a - 3 * cb) * f + (d + 2 * a - 3 * b) * UNITY;
    r  = frac_scale(p, UNITY - f);
    s  = floor_quot(r + 3, 6);
    t  = frac_scale(cb * UNITY - s, f);
    y  = b * UNITY + t;
    return clip_sample(floor_quot(y + UNITY / 2, UNITY));
  endfunction

  // ---------------------------------------------------------------------------
  // result checker, done is a one-cycle strobe that cannot be held off
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  always @(posedge clk_i) begin
    tap_expect_t want;
    if (rst_ni && done_o) begin
      if (pending_taps.size() == 0) begin
        report_mismatch($sformatf("unexpected tap %0d", tap_sample_o));
      end else begin
        want = pending_taps.pop_front();
        reads_checked++;
        if (tap_sample_o !== want.value)
          report_mismatch($sformatf("read #%0d tap_sample got %0d want %0d",
                                    want.seq, tap_sample_o, want.value));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // drivers: inputs move on the falling edge, handshakes are seen on the rising edge
  // ---------------------------------------------------------------------------

  // one word through start/busy; start stays high so the next word can follow at once
  task automatic send_word(input req_e kind, input logic signed [fdl_pkg::WS_W-1:0] ws,
                           input logic [fdl_pkg::TAP_W-1:0] pos);
    tap_expect_t want;
    @(negedge clk_i);
    start          <= 1'b1;
    req_type_i     <= kind;
    write_sample_i <= ws;
    tap_position_i <= pos;
    do @(posedge clk_i); while (busy);
    if (kind == REQ_WRITE) begin
      if (head_idx >= line_len) head_idx = 0;
      line_mirror[head_idx] = clip_sample(longint'(ws));
      head_idx++;
      if (head_idx >= line_len) head_idx = 0;
      writes_sent++;
    end else begin
      want.value = cubic_tap(pos);
      want.seq   = reads_sent;
      pending_taps.push_back(want);
      reads_sent++;
    end
  endtask

  task automatic hold_off(input int unsigned cycles);
    @(negedge clk_i);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // stop sending and wait until every owed tap is back and the block is quiet
  task automatic drain_line;
    int unsigned guard;
    guard = 0;
    @(negedge clk_i);
    start <= 1'b0;
    while ((pending_taps.size() != 0 || busy) && guard < DRAIN_GUARD) begin
      @(posedge clk_i);
      guard++;
    end
    if (pending_taps.size() != 0) begin
      report_mismatch($sformatf("%0d taps never arrived", pending_taps.size()));
      pending_taps.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // length register write, called with the block drained or still in its reset sweep
  task automatic set_length(input logic [fdl_pkg::LEN_W-1:0] value);
    int unsigned v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    v = value;
    if (v < MIN_LENGTH) v = MIN_LENGTH;
    if (v > STORE_DEPTH) v = STORE_DEPTH;
    line_len = v;
    if (head_idx >= line_len) head_idx = 0;
    if (line_len > max_len_seen) max_len_seen = line_len;
    length_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic signed [fdl_pkg::WS_W-1:0] pick_sample;
    longint v;
    case ($urandom_range(9))
      0: v = longint'($urandom_range(262143)) - 131072;
      1: v = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
      2: v = $urandom_range(1) ? 131071 : -131072;
      default: v = longint'($urandom_range(65535)) - 32768;
    endcase
    return v[fdl_pkg::WS_W-1:0];
  endfunction

  function automatic logic [fdl_pkg::TAP_W-1:0] pick_position;
    case ($urandom_range(7))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(255));
      default: return 16'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // lengths outside 4..DEPTH are clamped
  task automatic test_length_clamp;
    set_length(17'd0);
    set_length(17'd3);
    set_length(17'h1FFFF);
    set_length(17'd65537);
  endtask

  // out-of-range samples are stored saturated; the unused field is noise
  task automatic test_write_saturation;
    drain_line();
    set_length(17'd6);
    send_word(REQ_WRITE, 18'sd131071, 16'($urandom));
    send_word(REQ_WRITE, -18'sd131072, 16'($urandom));
    send_word(REQ_WRITE, 18'sd32768, 16'($urandom));
    send_word(REQ_WRITE, -18'sd32769, 16'($urandom));
    send_word(REQ_WRITE, 18'sd32767, 16'($urandom));
    send_word(REQ_WRITE, -18'sd32768, 16'($urandom));
    send_word(REQ_READ, pick_sample(), 16'd0);
    send_word(REQ_READ, pick_sample(), 16'hFFFF);
    send_word(REQ_READ, pick_sample(), 16'd10923);
  endtask

  // overshoot and undershoot of the cubic clip at full scale
  task automatic test_result_saturation;
    drain_line();
    set_length(17'd4);
    send_word(REQ_WRITE, -18'sd32768, 16'd0);
    send_word(REQ_WRITE, 18'sd32767, 16'd0);
    send_word(REQ_WRITE, 18'sd32767, 16'd0);
    send_word(REQ_WRITE, -18'sd32768, 16'd0);
    // head back at zero, tap lands halfway between entries one and two
    send_word(REQ_READ, 18'sd0, 16'd40960);
    send_word(REQ_WRITE, 18'sd32767, 16'd0);
    send_word(REQ_WRITE, -18'sd32768, 16'd0);
    send_word(REQ_WRITE, -18'sd32768, 16'd0);
    send_word(REQ_WRITE, 18'sd32767, 16'd0);
    send_word(REQ_READ, 18'sd0, 16'd40960);
  endtask

  // shrinking the length below the head sends the head back to zero
  task automatic test_length_shrink;
    int k;
    drain_line();
    set_length(17'd16);
    for (k = 0; k < 5; k++) send_word(REQ_WRITE, pick_sample(), pick_position());
    drain_line();
    set_length(17'd4);
    send_word(REQ_WRITE, 18'sd1234, 16'd0);
    send_word(REQ_READ, 18'sd0, 16'd16384);
  endtask

  // mixed traffic at one length, with random gaps when enabled and an occasional full drain
  task automatic test_random_traffic(input logic [fdl_pkg::LEN_W-1:0] length_val,
                                     input int count, input bit gaps_on);
    int k;
    drain_line();
    set_length(length_val);
    for (k = 0; k < count; k++) begin
      if ($urandom_range(99) < 55) send_word(REQ_WRITE, pick_sample(), 16'($urandom));
      else                         send_word(REQ_READ, 18'($urandom), pick_position());
      if (k == count / 2 || $urandom_range(99) == 0) drain_line();
      else if (gaps_on && $urandom_range(99) < 14) hold_off($urandom_range(1, 24));
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni         = 1'b0;
    start          = 1'b0;
    req_type_i     = REQ_READ;
    write_sample_i = '0;
    tap_position_i = '0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    cycle_count    = 0;
    mismatches     = 0;
    writes_sent    = 0;
    reads_sent     = 0;
    reads_checked  = 0;
    length_writes  = 0;
    max_len_seen   = 0;
    head_idx       = 0;
    line_len       = STORE_DEPTH;
    foreach (line_mirror[i]) line_mirror[i] = '0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_length_clamp();
    test_write_saturation();
    test_result_saturation();
    test_length_shrink();

    test_random_traffic(17'd4, 60, 1'b1);
    test_random_traffic(17'd5, 60, 1'b1);
    test_random_traffic(17'd17, 80, 1'b1);
    test_random_traffic(17'($urandom_range(4, 300)), 100, 1'b1);
    // back-to-back stretch with no gaps at all
    test_random_traffic(17'd37, 150, 1'b0);
    test_random_traffic(17'd65536, 60, 1'b1);
    test_random_traffic(17'($urandom_range(131071)), 90, 1'b1);

    drain_line();

    $display("ran %0d writes and %0d reads, %0d taps checked, %0d mismatches",
             writes_sent, reads_sent, reads_checked, mismatches);
    $display("%0d length writes up to %0d entries, with gaps, drains and clipping",
             length_writes, max_len_seen);
    if (mismatches == 0) begin
      $display("[fractional_delay_line] OK");
    end else begin
      $display("[fractional_delay_line] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
